// ===== rtl/tls_pkg.sv =====
// Shared types and codes for the token lexer stream.
`default_nettype none
package tls_pkg;

	localparam logic [1:0] RK_TEXT = 2'd0;
	localparam logic [1:0] RK_DONE = 2'd1;
	localparam logic [1:0] RK_DROP = 2'd2;
	localparam logic [1:0] RK_END  = 2'd3;

	localparam logic [2:0] TK_IDENT = 3'd0;
	localparam logic [2:0] TK_INT   = 3'd1;
	localparam logic [2:0] TK_STR   = 3'd2;
	localparam logic [2:0] TK_OPEN  = 3'd3;
	localparam logic [2:0] TK_CLOSE = 3'd4;
	localparam logic [2:0] TK_SEMI  = 3'd5;
	localparam logic [2:0] TK_EOF   = 3'd6;

	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_DIG_0 = 8'h30;
	localparam logic [7:0] CH_DIG_9 = 8'h39;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [1:0] result_kind;
		logic [2:0] token_kind;
		logic [7:0] text_char;
		logic       last_of_run;
	} res_t;

	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} lex_out_t;

endpackage
`default_nettype wire

// ===== rtl/tls_in_if.sv =====
// Input channel: one source character or end mark per word.
`default_nettype none
interface tls_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_input;

	modport source (output valid, output in_char, output end_of_input, input ready);
	modport sink (input valid, input in_char, input end_of_input, output ready);
endinterface
`default_nettype wire

// ===== rtl/tls_out_if.sv =====
// Output channel: one lexer result per word.
`default_nettype none
interface tls_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [2:0] token_kind;
	logic [7:0] text_char;
	logic       last_of_run;

	modport source (output valid, output result_kind, output token_kind, output text_char,
		output last_of_run, input ready);
	modport sink (input valid, input result_kind, input token_kind, input text_char,
		input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/token_lexer_stream.sv =====
// Top level of the streaming token lexer.
// A result passes through the input register and the result queue before it leaves.
// Throughput: one character a cycle while each gives at most one result and results are
// popped; output delivers one result a cycle, so two-result characters slow the input.
// The input register advances only when the four-entry result queue has two free places,
// counting a result that leaves in the same cycle.
// Reset: asynchronous, clears the lexer mode to default and empties the queue.
`default_nettype none
module token_lexer_stream (
	input  wire logic clk,
	input  wire logic arst_n,
	tls_in_if.sink    item,
	tls_out_if.source result
);

	logic              load;
	logic              room;
	logic              valid_s1;
	logic              advance;
	tls_pkg::lex_out_t lex;
	tls_pkg::res_t     out_res;

	assign item.ready = !valid_s1 || advance;
	assign load       = item.valid && item.ready;

	tls_lex u_lex (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.in_char      (item.in_char),
		.end_of_input (item.end_of_input),
		.room         (room),
		.valid_s1     (valid_s1),
		.advance      (advance),
		.lex          (lex)
	);

	tls_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.lex       (lex),
		.pop       (result.ready),
		.room      (room),
		.out_valid (result.valid),
		.out_res   (out_res)
	);

	assign result.result_kind = out_res.result_kind;
	assign result.token_kind  = out_res.token_kind;
	assign result.text_char   = out_res.text_char;
	assign result.last_of_run = out_res.last_of_run;

endmodule
`default_nettype wire

// ===== rtl/tls_lex.sv =====
// Input register, lexer mode register and the lexer decode logic.
`default_nettype none
module tls_lex (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire logic [7:0]      in_char,
	input  wire logic            end_of_input,
	input  wire logic            room,
	output logic                 valid_s1,
	output logic                 advance,
	output tls_pkg::lex_out_t    lex
);

	typedef enum logic [1:0] {
		M_DEF   = 2'd0,
		M_IDENT = 2'd1,
		M_INT   = 2'd2,
		M_STR   = 2'd3
	} mode_t;

	typedef struct packed {
		logic          hit;
		tls_pkg::res_t r;
		mode_t         m;
	} dflt_t;

	mode_t       mode_q;
	mode_t       mode_d;
	logic [7:0]  char_s1;
	logic        end_s1;
	logic        is_letter;
	logic        is_digit;
	dflt_t       dd;

	function automatic tls_pkg::res_t mk(input logic [1:0] rk, input logic [2:0] tk,
		input logic [7:0] ch);
		tls_pkg::res_t r;
		r.result_kind = rk;
		r.token_kind  = tk;
		r.text_char   = ch;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	assign is_letter = (char_s1 inside {[tls_pkg::CH_UP_A:tls_pkg::CH_UP_Z],
		[tls_pkg::CH_LO_A:tls_pkg::CH_LO_Z]});
	assign is_digit  = (char_s1 inside {[tls_pkg::CH_DIG_0:tls_pkg::CH_DIG_9]});

	always_comb begin
		dd.hit = 1'b0;
		dd.r   = '0;
		dd.m   = M_DEF;
		if (is_letter || char_s1 == tls_pkg::CH_UNDER) begin
			dd.hit = 1'b1;
			dd.r   = mk(tls_pkg::RK_TEXT, tls_pkg::TK_IDENT, char_s1);
			dd.m   = M_IDENT;
		end else if (is_digit || char_s1 == tls_pkg::CH_PLUS
			|| char_s1 == tls_pkg::CH_MINUS) begin
			dd.hit = 1'b1;
			dd.r   = mk(tls_pkg::RK_TEXT, tls_pkg::TK_INT, char_s1);
			dd.m   = M_INT;
		end else if (char_s1 == tls_pkg::CH_QUOTE) begin
			dd.m   = M_STR;
		end else if (char_s1 == tls_pkg::CH_OPEN) begin
			dd.hit = 1'b1;
			dd.r   = mk(tls_pkg::RK_DONE, tls_pkg::TK_OPEN, 8'd0);
		end else if (char_s1 == tls_pkg::CH_CLOSE) begin
			dd.hit = 1'b1;
			dd.r   = mk(tls_pkg::RK_DONE, tls_pkg::TK_CLOSE, 8'd0);
		end else if (char_s1 == tls_pkg::CH_SEMI) begin
			dd.hit = 1'b1;
			dd.r   = mk(tls_pkg::RK_DONE, tls_pkg::TK_SEMI, 8'd0);
		end
	end

	always_comb begin
		lex.count = 2'd0;
		lex.r0    = '0;
		lex.r1    = '0;
		mode_d    = mode_q;
		if (end_s1) begin
			mode_d = M_DEF;
			case (mode_q)
				M_IDENT: begin
					lex.r0 = mk(tls_pkg::RK_DROP, tls_pkg::TK_IDENT, 8'd0);
					lex.r1 = mk(tls_pkg::RK_END, tls_pkg::TK_EOF, 8'd0);
					lex.count = 2'd2;
				end
				M_INT: begin
					lex.r0 = mk(tls_pkg::RK_DROP, tls_pkg::TK_INT, 8'd0);
					lex.r1 = mk(tls_pkg::RK_END, tls_pkg::TK_EOF, 8'd0);
					lex.count = 2'd2;
				end
				M_STR: begin
					lex.r0 = mk(tls_pkg::RK_DROP, tls_pkg::TK_STR, 8'd0);
					lex.r1 = mk(tls_pkg::RK_END, tls_pkg::TK_EOF, 8'd0);
					lex.count = 2'd2;
				end
				default: begin
					lex.r0 = mk(tls_pkg::RK_END, tls_pkg::TK_EOF, 8'd0);
					lex.count = 2'd1;
				end
			endcase
		end else begin
			case (mode_q)
				M_IDENT: begin
					if (is_letter || is_digit || char_s1 == tls_pkg::CH_UNDER) begin
						lex.r0 = mk(tls_pkg::RK_TEXT, tls_pkg::TK_IDENT, char_s1);
						lex.count = 2'd1;
					end else begin
						lex.r0 = mk(tls_pkg::RK_DONE, tls_pkg::TK_IDENT, 8'd0);
						lex.r1 = dd.r;
						lex.count = dd.hit ? 2'd2 : 2'd1;
						mode_d = dd.m;
					end
				end
				M_INT: begin
					if (is_digit) begin
						lex.r0 = mk(tls_pkg::RK_TEXT, tls_pkg::TK_INT, char_s1);
						lex.count = 2'd1;
					end else begin
						lex.r0 = mk(tls_pkg::RK_DONE, tls_pkg::TK_INT, 8'd0);
						lex.r1 = dd.r;
						lex.count = dd.hit ? 2'd2 : 2'd1;
						mode_d = dd.m;
					end
				end
				M_STR: begin
					lex.count = 2'd1;
					if (char_s1 != tls_pkg::CH_QUOTE) begin
						lex.r0 = mk(tls_pkg::RK_TEXT, tls_pkg::TK_STR, char_s1);
					end else begin
						lex.r0 = mk(tls_pkg::RK_DONE, tls_pkg::TK_STR, 8'd0);
						mode_d = M_DEF;
					end
				end
				default: begin
					lex.r0 = dd.r;
					lex.count = dd.hit ? 2'd1 : 2'd0;
					mode_d = dd.m;
				end
			endcase
		end
		// mark the final result of the run
		if (lex.count == 2'd1) begin
			lex.r0.last_of_run = 1'b1;
		end else if (lex.count == 2'd2) begin
			lex.r1.last_of_run = 1'b1;
		end
	end

	assign advance = valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= M_DEF;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				mode_q <= mode_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_s1 <= in_char;
			end_s1  <= end_of_input;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tls_res_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one a cycle while popped.
`default_nettype none
module tls_res_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire tls_pkg::lex_out_t lex,
	input  wire logic              pop,
	output logic                   room,
	output logic                   out_valid,
	output tls_pkg::res_t          out_res
);

	tls_pkg::res_t                ent_q [tls_pkg::FIFO_DEPTH];
	logic [tls_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [tls_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [tls_pkg::FIFO_AW:0]    cnt_q;
	logic [1:0]                   n_push;
	logic                         do_pop;

	assign do_pop    = pop && out_valid;
	assign n_push    = push ? lex.count : 2'd0;
	assign out_valid = (cnt_q != '0);
	assign out_res   = ent_q[rd_ptr_q];
	assign room      = (cnt_q <= (tls_pkg::FIFO_AW + 1)'(tls_pkg::FIFO_DEPTH - 2))
		|| ((cnt_q == (tls_pkg::FIFO_AW + 1)'(tls_pkg::FIFO_DEPTH - 1)) && do_pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + tls_pkg::FIFO_AW'(n_push);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + tls_pkg::FIFO_AW'(1);
			end
			cnt_q <= cnt_q + (tls_pkg::FIFO_AW + 1)'(n_push)
				- (tls_pkg::FIFO_AW + 1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			ent_q[wr_ptr_q] <= lex.r0;
		end
		if (n_push == 2'd2) begin
			ent_q[wr_ptr_q + tls_pkg::FIFO_AW'(1)] <= lex.r1;
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/token_lexer_stream_checker.sv =====
// Checker for the token lexer stream: predicts the results of each taken word and compares them.
`timescale 1ns / 1ps
module token_lexer_stream_checker
	import tls_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tls_in_if    item_mon,
	tls_out_if   result_mon,
	output int   errors,
	output int   outstanding
);

	typedef enum logic [1:0] {
		LEX_DEFAULT = 2'd0,
		LEX_IDENT   = 2'd1,
		LEX_INT     = 2'd2,
		LEX_STR     = 2'd3
	} lex_mode_e;

	lex_mode_e lex_mode;
	res_t      token_results_q[$];
	res_t      word_results_q[$];
	res_t      seen;
	res_t      want;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_DIG_0 && c <= CH_DIG_9;
	endfunction

	task automatic add_result(input logic [1:0] rk, input logic [2:0] tk, input logic [7:0] ch);
		res_t r;
		r.result_kind = rk;
		r.token_kind  = tk;
		r.text_char   = ch;
		r.last_of_run = 1'b0;
		word_results_q.push_back(r);
	endtask

	task automatic lex_from_default(input logic [7:0] c);
		if (is_letter(c) || c == CH_UNDER) begin
			add_result(RK_TEXT, TK_IDENT, c);
			lex_mode = LEX_IDENT;
		end else if (is_digit(c) || c == CH_PLUS || c == CH_MINUS) begin
			add_result(RK_TEXT, TK_INT, c);
			lex_mode = LEX_INT;
		end else if (c == CH_QUOTE) begin
			lex_mode = LEX_STR;
		end else if (c == CH_OPEN) begin
			add_result(RK_DONE, TK_OPEN, 8'h00);
		end else if (c == CH_CLOSE) begin
			add_result(RK_DONE, TK_CLOSE, 8'h00);
		end else if (c == CH_SEMI) begin
			add_result(RK_DONE, TK_SEMI, 8'h00);
		end
	endtask

	task automatic predict_tokens(input logic [7:0] c, input logic eoi);
		res_t tail;
		word_results_q.delete();
		if (eoi) begin
			case (lex_mode)
				LEX_IDENT: add_result(RK_DROP, TK_IDENT, 8'h00);
				LEX_INT:   add_result(RK_DROP, TK_INT, 8'h00);
				LEX_STR:   add_result(RK_DROP, TK_STR, 8'h00);
				default:   ;
			endcase
			add_result(RK_END, TK_EOF, 8'h00);
			lex_mode = LEX_DEFAULT;
		end else begin
			case (lex_mode)
				LEX_IDENT: begin
					if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
						add_result(RK_TEXT, TK_IDENT, c);
					end else begin
						add_result(RK_DONE, TK_IDENT, 8'h00);
						lex_mode = LEX_DEFAULT;
						lex_from_default(c);
					end
				end
				LEX_INT: begin
					if (is_digit(c)) begin
						add_result(RK_TEXT, TK_INT, c);
					end else begin
						add_result(RK_DONE, TK_INT, 8'h00);
						lex_mode = LEX_DEFAULT;
						lex_from_default(c);
					end
				end
				LEX_STR: begin
					if (c != CH_QUOTE) begin
						add_result(RK_TEXT, TK_STR, c);
					end else begin
						add_result(RK_DONE, TK_STR, 8'h00);
						lex_mode = LEX_DEFAULT;
					end
				end
				default: lex_from_default(c);
			endcase
		end
		if (word_results_q.size() > 0) begin
			tail = word_results_q.pop_back();
			tail.last_of_run = 1'b1;
			word_results_q.push_back(tail);
		end
		foreach (word_results_q[i]) token_results_q.push_back(word_results_q[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_mode = LEX_DEFAULT;
			token_results_q.delete();
			errors      = 0;
			outstanding = 0;
		end else begin
			if (item_mon.valid && item_mon.ready)
				predict_tokens(item_mon.in_char, item_mon.end_of_input);
			if (result_mon.valid && result_mon.ready) begin
				seen.result_kind = result_mon.result_kind;
				seen.token_kind  = result_mon.token_kind;
				seen.text_char   = result_mon.text_char;
				seen.last_of_run = result_mon.last_of_run;
				if (token_results_q.size() == 0) begin
					$error("unexpected result word: result_kind %0d token_kind %0d text_char %0d",
						seen.result_kind, seen.token_kind, seen.text_char);
					errors++;
				end else begin
					want = token_results_q.pop_front();
					if (seen.result_kind !== want.result_kind) begin
						$error("result_kind: expected %0d, got %0d", want.result_kind,
							seen.result_kind);
						errors++;
					end
					if (seen.token_kind !== want.token_kind) begin
						$error("token_kind: expected %0d, got %0d", want.token_kind,
							seen.token_kind);
						errors++;
					end
					if (seen.text_char !== want.text_char) begin
						$error("text_char: expected %0d, got %0d", want.text_char,
							seen.text_char);
						errors++;
					end
					if (seen.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0d, got %0d", want.last_of_run,
							seen.last_of_run);
						errors++;
					end
				end
			end
			outstanding = token_results_q.size();
		end
	end

endmodule

// ===== tb/sv/token_lexer_stream_tb.sv =====
// Testbench top for the token lexer stream: clock, reset, character stimulus and verdict.
`timescale 1ns / 1ps
module token_lexer_stream_tb;
	import tls_pkg::*;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam int         WORD_TARGET = 1250;

	logic clk;
	logic arst_n;
	bit   idle_on;
	int   words_sent;
	int   fail_count;
	int   outstanding;

	tls_in_if  item_ch ();
	tls_out_if result_ch ();

	token_lexer_stream uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	token_lexer_stream_checker lex_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_mon    (item_ch),
		.result_mon  (result_ch),
		.errors      (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("FAIL");
		$finish;
	end

	always @(negedge clk) begin
		if (idle_on)
			result_ch.ready <= ($urandom_range(99) >= 9);
		else
			result_ch.ready <= 1'b1;
	end

	task automatic send_word(input logic [7:0] ch, input logic eoi, input bit counts);
		while (idle_on && $urandom_range(99) < 9) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.in_char      <= ch;
		item_ch.end_of_input <= eoi;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		@(negedge clk);
		if (counts) words_sent++;
	endtask

	function automatic logic [7:0] any_letter();
		if ($urandom_range(1))
			return 8'($urandom_range(CH_UP_A, CH_UP_Z));
		return 8'($urandom_range(CH_LO_A, CH_LO_Z));
	endfunction

	function automatic logic [7:0] any_digit();
		return 8'($urandom_range(CH_DIG_0, CH_DIG_9));
	endfunction

	task automatic send_ident();
		int len;
		len = $urandom_range(7);
		send_word(($urandom_range(4) == 0) ? CH_UNDER : any_letter(), 1'b0, 1'b1);
		repeat (len) begin
			case ($urandom_range(3))
				0, 1:    send_word(any_letter(), 1'b0, 1'b1);
				2:       send_word(any_digit(), 1'b0, 1'b1);
				default: send_word(CH_UNDER, 1'b0, 1'b1);
			endcase
		end
	endtask

	task automatic send_int();
		int len;
		if ($urandom_range(2) == 0) begin
			send_word($urandom_range(1) ? CH_PLUS : CH_MINUS, 1'b0, 1'b1);
			len = $urandom_range(5);
		end else begin
			len = $urandom_range(1, 6);
		end
		repeat (len) send_word(any_digit(), 1'b0, 1'b1);
	endtask

	task automatic send_string(input bit closed);
		int         len;
		logic [7:0] b;
		len = $urandom_range(8);
		send_word(CH_QUOTE, 1'b0, 1'b1);
		repeat (len) begin
			do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
			send_word(b, 1'b0, 1'b1);
		end
		if (closed) send_word(CH_QUOTE, 1'b0, 1'b1);
	endtask

	task automatic send_punct();
		case ($urandom_range(2))
			0:       send_word(CH_OPEN, 1'b0, 1'b1);
			1:       send_word(CH_CLOSE, 1'b0, 1'b1);
			default: send_word(CH_SEMI, 1'b0, 1'b1);
		endcase
	endtask

	initial begin
		bit paused;
		arst_n                 = 1'b0;
		idle_on                = 1'b1;
		paused                 = 1'b0;
		words_sent             = 0;
		item_ch.valid          = 1'b0;
		item_ch.in_char        = 8'h00;
		item_ch.end_of_input   = 1'b0;
		result_ch.ready        = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: class extremes, two-result words, empty string, drops in string and integer mode
		send_word(8'h00, 1'b0, 1'b1);
		send_word(CH_UP_A, 1'b0, 1'b1);
		send_word(CH_LO_Z, 1'b0, 1'b1);
		send_word(CH_DIG_9, 1'b0, 1'b1);
		send_word(CH_UNDER, 1'b0, 1'b1);
		send_word(CH_OPEN, 1'b0, 1'b1);
		send_word(CH_MINUS, 1'b0, 1'b1);
		send_word(CH_PLUS, 1'b0, 1'b1);
		send_word(CH_DIG_0, 1'b0, 1'b1);
		send_word(CH_SEMI, 1'b0, 1'b1);
		send_word(CH_QUOTE, 1'b0, 1'b1);
		send_word(CH_QUOTE, 1'b0, 1'b1);
		send_word(CH_QUOTE, 1'b0, 1'b1);
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'hFF, 1'b0, 1'b1);
		send_word(8'h80, 1'b0, 1'b1);
		send_word(8'hFF, 1'b1, 1'b1);
		send_word(CH_LO_A, 1'b0, 1'b1);
		send_word(CH_QUOTE, 1'b0, 1'b1);
		send_word(CH_UP_Z, 1'b0, 1'b1);
		send_word(8'h00, 1'b1, 1'b1);
		send_word(CH_DIG_0, 1'b0, 1'b1);
		send_word(CH_CLOSE, 1'b1, 1'b1);
		send_word(8'h7F, 1'b0, 1'b1);
		send_word(8'h00, 1'b1, 1'b1);

		// hold off until every expected result is back
		item_ch.valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);

		while (words_sent < WORD_TARGET) begin
			idle_on = !(words_sent >= 500 && words_sent < 750);
			if (!paused && words_sent >= 900) begin
				paused = 1'b1;
				item_ch.valid <= 1'b0;
				wait (outstanding == 0);
				@(negedge clk);
			end
			case ($urandom_range(99)) inside
				[0:27]:  send_ident();
				[28:49]: send_int();
				[50:64]: send_string(1'b1);
				[65:79]: send_punct();
				[80:86]: begin
					case ($urandom_range(2))
						0:       send_ident();
						1:       send_int();
						default: send_string(1'b0);
					endcase
					send_word(8'($urandom_range(255)), 1'b1, 1'b1);
				end
				[87:94]: repeat ($urandom_range(1, 3))
					send_word(8'($urandom_range(255)), 1'b0, 1'b1);
				default: send_word(8'($urandom_range(255)), 1'b1, 1'b1);
			endcase
			if ($urandom_range(1)) send_word(CH_SPACE, 1'b0, 1'b1);
		end
		send_word(8'h00, 1'b1, 1'b1);

		item_ch.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
